FILE: rtl/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared types and constants for the largest connected component block:
// request codes, field widths, sequencer states and inter-module structs.
// ----------------------------------------------------------------------------
package lcc_pkg;

   // Fixed field widths of the request, result and register beats.
   localparam int CNT_W     = 7;
   localparam int NODE_IN_W = 6;
   localparam int REQ_W     = 2;

   localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 7'd64;

   // Request codes carried in req_type.
   localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_EDGE    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

   typedef enum logic [1:0] {
      ADJ_SWEEP,
      ADJ_IDLE,
      ADJ_EDGE_A,
      ADJ_EDGE_B
   } lcc_adj_state_type;

   typedef enum logic [2:0] {
      WALK_IDLE,
      WALK_START,
      WALK_SCAN,
      WALK_POP,
      WALK_DONE
   } lcc_walk_state_type;

   // One accepted request, already decoded and range checked.
   typedef struct packed {
      logic                 clear;
      logic                 edge_add;
      logic                 compute;
      logic [NODE_IN_W-1:0] node_a;
      logic [NODE_IN_W-1:0] node_b;
      logic [CNT_W-1:0]     node_num;
   } lcc_cmd_type;

   // Status of the walker towards the top level.
   typedef struct packed {
      logic             busy;
      logic             result;
      logic [CNT_W-1:0] size;
   } lcc_walk_stat_type;

endpackage

FILE: rtl/lcc_adj.sv
// ----------------------------------------------------------------------------
// lcc_adj
// Adjacency matrix store: one row of bits per node in a single-port-write,
// single-port-read memory. Runs the clearing pass, sets both symmetric bits
// of an edge by read-modify-write, and serves row reads to the walker.
// ----------------------------------------------------------------------------
module lcc_adj #(
   parameter int MAX_NODES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lcc_pkg::lcc_cmd_type       cmd,
   input  logic                       walk_rd_en,
   input  logic [$clog2(MAX_NODES)-1:0] walk_rd_addr,
   output logic [MAX_NODES-1:0]       rd_data,
   output logic                       busy
);
   import lcc_pkg::*;

   localparam int NODE_W = $clog2(MAX_NODES);

   lcc_adj_state_type state_ff, state_in;

   logic [NODE_W-1:0]    sweep_ff, sweep_in;
   logic [NODE_W-1:0]    a_ff, a_in;
   logic [NODE_W-1:0]    b_ff, b_in;

   logic                 wr_en;
   logic [NODE_W-1:0]    wr_addr;
   logic [MAX_NODES-1:0] wr_data;
   logic                 rd_en;
   logic [NODE_W-1:0]    rd_addr;

   logic [MAX_NODES-1:0] row_mem [MAX_NODES];
   logic [MAX_NODES-1:0] rd_data_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ADJ_SWEEP: begin
            if (sweep_ff == NODE_W'(MAX_NODES - 1)) begin
               state_in = ADJ_IDLE;
            end
         end
         ADJ_IDLE: begin
            if (cmd.clear) begin
               state_in = ADJ_SWEEP;
            end else if (cmd.edge_add) begin
               state_in = ADJ_EDGE_A;
            end
         end
         ADJ_EDGE_A: state_in = ADJ_EDGE_B;
         ADJ_EDGE_B: state_in = ADJ_IDLE;
         default:    state_in = ADJ_IDLE;
      endcase
   end

   // Memory port control and held operands
   always_comb begin
      sweep_in = sweep_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      wr_en    = 1'b0;
      wr_addr  = sweep_ff;
      wr_data  = '0;
      rd_en    = 1'b0;
      rd_addr  = walk_rd_addr;
      unique case (state_ff)
         ADJ_SWEEP: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            sweep_in = sweep_ff + NODE_W'(1);
         end
         ADJ_IDLE: begin
            if (cmd.clear) begin
               sweep_in = '0;
            end else if (cmd.edge_add) begin
               a_in    = NODE_W'(cmd.node_a);
               b_in    = NODE_W'(cmd.node_b);
               rd_en   = 1'b1;
               rd_addr = NODE_W'(cmd.node_a);
            end else begin
               rd_en   = walk_rd_en;
               rd_addr = walk_rd_addr;
            end
         end
         ADJ_EDGE_A: begin
            // A self-loop reads the old row here; the second write sets the same bit.
            wr_en   = 1'b1;
            wr_addr = a_ff;
            wr_data = rd_data_ff | (MAX_NODES'(1) << b_ff);
            rd_en   = 1'b1;
            rd_addr = b_ff;
         end
         ADJ_EDGE_B: begin
            wr_en   = 1'b1;
            wr_addr = b_ff;
            wr_data = rd_data_ff | (MAX_NODES'(1) << a_ff);
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ADJ_SWEEP;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= row_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = (state_ff != ADJ_IDLE);

endmodule

FILE: rtl/lcc_walk.sv
// ----------------------------------------------------------------------------
// lcc_walk
// Depth-first walk over the adjacency rows with an explicit return stack.
// A single compare step tests one row bit per cycle; the sequencer pushes,
// pops and moves on to the next unvisited start node, keeping the best size.
// ----------------------------------------------------------------------------
module lcc_walk #(
   parameter int MAX_NODES = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lcc_pkg::lcc_cmd_type         cmd,
   input  logic [MAX_NODES-1:0]         adj_rd_data,
   input  logic                         out_free,
   output logic                         adj_rd_en,
   output logic [$clog2(MAX_NODES)-1:0] adj_rd_addr,
   output lcc_pkg::lcc_walk_stat_type   stat
);
   import lcc_pkg::*;

   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int STK_W  = NODE_W + CNT_W;

   lcc_walk_state_type state_ff, state_in;

   logic [CNT_W-1:0]     n_ff, n_in;
   logic [CNT_W-1:0]     start_ff, start_in;
   logic [CNT_W-1:0]     y_ff, y_in;
   logic [NODE_W-1:0]    z_ff, z_in;
   logic [CNT_W-1:0]     sp_ff, sp_in;
   logic [CNT_W-1:0]     comp_ff, comp_in;
   logic [CNT_W-1:0]     best_ff, best_in;
   logic [MAX_NODES-1:0] visited_ff, visited_in;

   logic [NODE_W-1:0]    y_idx;
   logic [NODE_W-1:0]    start_idx;
   logic                 scan_end;
   logic                 start_end;
   logic                 hit;
   logic                 last_entry;

   logic                 stk_we;
   logic [NODE_W-1:0]    stk_waddr;
   logic [STK_W-1:0]     stk_wdata;
   logic                 stk_re;
   logic [NODE_W-1:0]    stk_raddr;
   logic [STK_W-1:0]     stk_mem [MAX_NODES];
   logic [STK_W-1:0]     stk_rdata_ff;

   assign y_idx      = NODE_W'(y_ff);
   assign start_idx  = NODE_W'(start_ff);
   assign scan_end   = (y_ff == n_ff);
   assign start_end  = (start_ff == n_ff);
   assign last_entry = (sp_ff == CNT_W'(1));
   // The single compare step: an edge to a node not yet seen, self-loops excluded.
   assign hit        = adj_rd_data[y_idx] && !visited_ff[y_idx] && (y_idx != z_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         WALK_IDLE: begin
            if (cmd.compute) begin
               state_in = WALK_START;
            end
         end
         WALK_START: begin
            if (start_end) begin
               state_in = WALK_DONE;
            end else if (!visited_ff[start_idx]) begin
               state_in = WALK_SCAN;
            end
         end
         WALK_SCAN: begin
            if (scan_end) begin
               state_in = last_entry ? WALK_START : WALK_POP;
            end
         end
         WALK_POP: state_in = WALK_SCAN;
         WALK_DONE: begin
            if (out_free) begin
               state_in = WALK_IDLE;
            end
         end
         default: state_in = WALK_IDLE;
      endcase
   end

   // Datapath and memory port control
   always_comb begin
      n_in        = n_ff;
      start_in    = start_ff;
      y_in        = y_ff;
      z_in        = z_ff;
      sp_in       = sp_ff;
      comp_in     = comp_ff;
      best_in     = best_ff;
      visited_in  = visited_ff;
      adj_rd_en   = 1'b0;
      adj_rd_addr = z_ff;
      stk_we      = 1'b0;
      stk_waddr   = NODE_W'(sp_ff - CNT_W'(1));
      stk_wdata   = {z_ff, CNT_W'(y_ff + CNT_W'(1))};
      stk_re      = 1'b0;
      stk_raddr   = NODE_W'(sp_ff - CNT_W'(2));
      unique case (state_ff)
         WALK_IDLE: begin
            if (cmd.compute) begin
               n_in       = cmd.node_num;
               start_in   = '0;
               best_in    = '0;
               visited_in = '0;
            end
         end
         WALK_START: begin
            if (!start_end) begin
               if (visited_ff[start_idx]) begin
                  start_in = start_ff + CNT_W'(1);
               end else begin
                  visited_in[start_idx] = 1'b1;
                  comp_in     = CNT_W'(1);
                  sp_in       = CNT_W'(1);
                  z_in        = start_idx;
                  y_in        = '0;
                  adj_rd_en   = 1'b1;
                  adj_rd_addr = start_idx;
               end
            end
         end
         WALK_SCAN: begin
            if (scan_end) begin
               sp_in = sp_ff - CNT_W'(1);
               if (last_entry) begin
                  if (comp_ff > best_ff) begin
                     best_in = comp_ff;
                  end
                  start_in = start_ff + CNT_W'(1);
               end else begin
                  stk_re = 1'b1;
               end
            end else if (hit) begin
               // Save where this node resumes, then descend into the new node.
               visited_in[y_idx] = 1'b1;
               comp_in     = comp_ff + CNT_W'(1);
               stk_we      = 1'b1;
               z_in        = y_idx;
               y_in        = '0;
               sp_in       = sp_ff + CNT_W'(1);
               adj_rd_en   = 1'b1;
               adj_rd_addr = y_idx;
            end else begin
               y_in = y_ff + CNT_W'(1);
            end
         end
         WALK_POP: begin
            z_in        = stk_rdata_ff[STK_W-1 -: NODE_W];
            y_in        = stk_rdata_ff[CNT_W-1:0];
            adj_rd_en   = 1'b1;
            adj_rd_addr = stk_rdata_ff[STK_W-1 -: NODE_W];
         end
         WALK_DONE: begin
            adj_rd_en = 1'b0;
         end
         default: begin
            adj_rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= WALK_IDLE;
         sp_ff      <= '0;
         comp_ff    <= '0;
         best_ff    <= '0;
         visited_ff <= '0;
      end else begin
         state_ff   <= state_in;
         sp_ff      <= sp_in;
         comp_ff    <= comp_in;
         best_ff    <= best_in;
         visited_ff <= visited_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      start_ff <= start_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rdata_ff <= stk_mem[stk_raddr];
      end
   end

   assign stat.busy   = (state_ff != WALK_IDLE);
   assign stat.result = (state_ff == WALK_DONE) && out_free;
   assign stat.size   = best_ff;

endmodule

FILE: rtl/largest_connected_component.sv
// ----------------------------------------------------------------------------
// largest_connected_component
// Keeps an undirected graph as a bit adjacency matrix and returns the size
// of its largest connected component on request.
// ----------------------------------------------------------------------------
//
//   Port group   Direction   Handshake          Carries
//   req_*        in          valid / stall      request type, two node numbers
//   rsp_*        out         valid / stall      size of the largest component
//   csr_*        in          write enable only  node count in use
//
// A clear beat zeroes the matrix one row a cycle.
// An edge beat does a read-modify-write of each of the two rows.
// A compute beat walks the n nodes in use and tests one row bit per cycle
// while scanning; pop and start-node steps come between the scans.
// After reset the matrix is cleared with req_stall high.
// A result waits in the output register; the next request beat is taken
// meanwhile, and a later result is held back until that register is free.
// ----------------------------------------------------------------------------
module largest_connected_component #(
   parameter int MAX_NODES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lcc_pkg::REQ_W-1:0]      req_type,
   input  logic [lcc_pkg::NODE_IN_W-1:0]  req_node_a,
   input  logic [lcc_pkg::NODE_IN_W-1:0]  req_node_b,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lcc_pkg::CNT_W-1:0]      rsp_largest_size,
   input  logic                           csr_wr_en,
   input  logic [lcc_pkg::CNT_W-1:0]      csr_wr_data
);
   import lcc_pkg::*;

   localparam int NODE_W  = $clog2(MAX_NODES);
   localparam int CNT_TOP = (1 << CNT_W) - 1;
   localparam int CNT_MAX = (MAX_NODES < CNT_TOP) ? MAX_NODES : CNT_TOP;

   logic [CNT_W-1:0]     node_count_ff;
   logic [CNT_W-1:0]     node_num;
   logic                 accept;
   lcc_cmd_type          cmd;
   logic                 adj_busy;
   logic [MAX_NODES-1:0] adj_rd_data;
   logic                 adj_rd_en;
   logic [NODE_W-1:0]    adj_rd_addr;
   lcc_walk_stat_type    walk_stat;
   logic                 out_free;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]     rsp_size_ff, rsp_size_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   // Node count saturated to what the matrix holds.
   assign node_num = (node_count_ff > CNT_W'(CNT_MAX)) ? CNT_W'(CNT_MAX) : node_count_ff;

   assign req_stall = adj_busy || walk_stat.busy;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd.clear    = accept && (req_type == REQ_CLEAR);
      cmd.edge_add = accept && (req_type == REQ_EDGE) &&
                     (CNT_W'(req_node_a) < node_num) && (CNT_W'(req_node_b) < node_num);
      cmd.compute  = accept && (req_type == REQ_COMPUTE);
      cmd.node_a   = req_node_a;
      cmd.node_b   = req_node_b;
      cmd.node_num = node_num;
   end

   lcc_adj #(
      .MAX_NODES (MAX_NODES)
   ) u_adj (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .walk_rd_en   (adj_rd_en),
      .walk_rd_addr (adj_rd_addr),
      .rd_data      (adj_rd_data),
      .busy         (adj_busy)
   );

   lcc_walk #(
      .MAX_NODES (MAX_NODES)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .adj_rd_data (adj_rd_data),
      .out_free    (out_free),
      .adj_rd_en   (adj_rd_en),
      .adj_rd_addr (adj_rd_addr),
      .stat        (walk_stat)
   );

   // Output register: free when empty or when its beat is taken this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_size_in  = rsp_size_ff;
      if (walk_stat.result) begin
         rsp_valid_in = 1'b1;
         rsp_size_in  = walk_stat.size;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_size_ff <= rsp_size_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_largest_size = rsp_size_ff;

   // The walk and the matrix sequencer never run at the same time.
   a_no_overlap : assert property (@(posedge clock) disable iff (reset)
      !(walk_stat.busy && adj_busy))
      else $error("walk active while matrix sequencer busy");

   // The clearing pass after reset blocks requests.
   a_sweep_after_reset : assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("request port open during clearing pass");

   // A component can never be larger than the graph.
   a_size_bound : assert property (@(posedge clock) disable iff (reset)
      walk_stat.result |-> (32'(walk_stat.size) <= MAX_NODES))
      else $error("component size exceeds node capacity");

endmodule
